// File: design/chip8_instruction_core_defines.svh
// Assertion macros for the chip8 instruction core
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define C8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define C8_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define C8_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/c8_pkg.sv
// ----------------------------------------------------------------------------
// c8_pkg: shared types and constants for the chip8 instruction core
// Input and result beat structs, function codes, sizes.
// ----------------------------------------------------------------------------
package c8_pkg;
    localparam int MEM_BYTES_C   = 4096;
    localparam int STACK_DEPTH_C = 16;
    localparam int SCREEN_W_C    = 64;
    localparam int SCREEN_H_C    = 32;
    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_EXEC  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } cmd_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [11:0] index_value;
        logic [7:0]  flag_value;
        logic        screen_changed;
        logic        unknown_opcode;
        logic [63:0] display_row;
    } rsp_t;
endpackage

// File: design/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 interpreter core
// Memory load, single-instruction execute and display row read.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; busy then stays high
// until the result beat, shown with done high for exactly one cycle (the
// receiver cannot stall it). A memory write passes through S_MEMWT, a row
// read goes straight to S_DONE. An instruction is fetched and executed in
// S_FETCH, S_HI, S_LO and S_EXEC through the single port of the 4 KiB memory
// and the shared ALU; a draw adds S_DREAD and S_DXOR for each sprite row (one
// memory read, then one XOR into the display), and a clear walks all 32
// display rows, one per cycle.
module chip8_instruction_core
    import c8_pkg::cmd_t;
    import c8_pkg::rsp_t;
#(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_C
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp,
    input  logic cfg_we,
    input  logic cfg_wdata
);
    import c8_pkg::*;
`include "chip8_instruction_core_defines.svh"

    localparam int SW = $clog2(STACK_DEPTH);
    localparam logic [SW-1:0] SP_LAST = SW'(STACK_DEPTH - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FETCH = 10'b0000000010,
        S_HI    = 10'b0000000100,
        S_LO    = 10'b0000001000,
        S_EXEC  = 10'b0000010000,
        S_CLEAR = 10'b0000100000,
        S_DREAD = 10'b0001000000,
        S_DXOR  = 10'b0010000000,
        S_MEMWT = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic   quirk_reg;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] i_reg, i_next;
    logic [7:0]  v_reg [16];
    logic [11:0] stk_reg [STACK_DEPTH];
    logic [SW-1:0] sp_reg, sp_next;
    logic [SW-1:0] sp_prev, sp_inc;
    logic [63:0] fb_reg [32];
    logic [7:0]  hi_reg;
    logic [15:0] op_reg;
    logic [5:0]  px_reg;
    logic [4:0]  py_reg;
    logic [4:0]  row_reg, row_next;
    logic        drawn_reg, drawn_next;
    logic        unk_reg, unk_next;
    logic [63:0] disp_reg, disp_next;

    // memory port
    logic        mem_we;
    logic [11:0] mem_addr;
    logic [7:0]  mem_rdata;

    c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_BYTES_C)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(cmd_reg.data),
        .rdata(mem_rdata)
    );

    // decoded fields
    logic [3:0]  ox, oy, on;
    logic [7:0]  onn, vx, vy;
    logic [11:0] onnn;
    assign ox   = op_reg[11:8];
    assign oy   = op_reg[7:4];
    assign on   = op_reg[3:0];
    assign onn  = op_reg[7:0];
    assign onnn = op_reg[11:0];
    assign vx   = v_reg[ox];
    assign vy   = v_reg[oy];

    // stack level wraps over the full depth in both directions
    assign sp_prev = (sp_reg == '0) ? SP_LAST : sp_reg - SW'(1);
    assign sp_inc  = (sp_reg == SP_LAST) ? '0 : sp_reg + SW'(1);

    logic [3:0] alu_op;
    logic [7:0] alu_a, alu_b, alu_res;
    logic       alu_flag;

    c8_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .flag(alu_flag)
    );

    // ALU operands: 8XY_ uses VX/VY (quirk shifts copy VY); skips use xor compare
    always_comb
    begin
        alu_op = on;
        alu_a  = vx;
        alu_b  = vy;
        if (op_reg[15:12] == 4'h8)
        begin
            if (quirk_reg && (on == 4'h6 || on == 4'hE))
            begin
                alu_a = vy;
            end
        end
        else
        begin
            alu_op = 4'h3;
            alu_b  = (op_reg[15:12] == 4'h5 || op_reg[15:12] == 4'h9) ? vy : onn;
        end
    end

    // sprite geometry, held from the execute cycle since VF may be a coordinate
    logic [5:0]  px;
    logic [4:0]  py;
    logic [5:0]  drow;
    logic [63:0] smask;
    assign px    = px_reg;
    assign py    = py_reg;
    assign drow  = {1'b0, py} + {1'b0, row_reg};
    assign smask = {mem_rdata, 56'd0} >> px;

    logic key_hit;
    assign key_hit = (vx[7:4] == 4'd0) && cmd_reg.key_mask[vx[3:0]];

    // write strobes for register files
    logic        v_we, vf_we;
    logic [3:0]  v_wa;
    logic [7:0]  v_wd, vf_wd;
    logic        stk_we;
    logic        fb_we;
    logic [4:0]  fb_wa;
    logic [63:0] fb_wd;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        i_next     = i_reg;
        sp_next    = sp_reg;
        row_next   = row_reg;
        drawn_next = drawn_reg;
        unk_next   = unk_reg;
        disp_next  = disp_reg;
        mem_we     = 1'b0;
        mem_addr   = pc_reg;
        v_we       = 1'b0;
        v_wa       = ox;
        v_wd       = alu_res;
        vf_we      = 1'b0;
        vf_wd      = 8'd0;
        stk_we     = 1'b0;
        fb_we      = 1'b0;
        fb_wa      = row_reg;
        fb_wd      = 64'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    drawn_next = 1'b0;
                    unk_next   = 1'b0;
                    disp_next  = 64'd0;
                    row_next   = 5'd0;
                    case (func_t'(cmd.func))
                        FUNC_WRITE: state_next = S_MEMWT;
                        FUNC_EXEC:  state_next = S_FETCH;
                        FUNC_READ:
                        begin
                            disp_next  = fb_reg[cmd.row_select];
                            state_next = S_DONE;
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_MEMWT:
            begin
                mem_we     = 1'b1;
                mem_addr   = cmd_reg.address;
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                mem_addr   = pc_reg;
                state_next = S_HI;
            end
            S_HI:
            begin
                mem_addr   = pc_reg + 12'd1;
                state_next = S_LO;
            end
            S_LO:
            begin
                pc_next    = pc_reg + 12'd2;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00E0)
                        begin
                            row_next   = 5'd0;
                            state_next = S_CLEAR;
                        end
                        else if (op_reg == 16'h00EE)
                        begin
                            sp_next = sp_prev;
                            pc_next = stk_reg[sp_prev];
                        end
                        else if (onn != 8'd0)
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    4'h1: pc_next = onnn;
                    4'h2:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = onnn;
                    end
                    4'h3: if (alu_res == 8'd0) pc_next = pc_reg + 12'd2;
                    4'h4, 4'h9: if (alu_res != 8'd0) pc_next = pc_reg + 12'd2;
                    4'h5: if (alu_res == 8'd0) pc_next = pc_reg + 12'd2;
                    4'h6:
                    begin
                        v_we = 1'b1;
                        v_wd = onn;
                    end
                    4'h7:
                    begin
                        v_we = 1'b1;
                        v_wd = vx + onn;
                    end
                    4'h8:
                    begin
                        if (on inside {4'h0, 4'h1, 4'h2, 4'h3})
                        begin
                            v_we = 1'b1;
                        end
                        else if (on inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE})
                        begin
                            v_we  = 1'b1;
                            vf_we = 1'b1;
                            vf_wd = {7'd0, alu_flag};
                        end
                        else
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    4'hA: i_next = onnn;
                    4'hB: pc_next = onnn + {4'd0, (quirk_reg ? v_reg[0] : vx)};
                    4'hC:
                    begin
                        v_we = 1'b1;
                        v_wd = cmd_reg.random_byte & onn;
                    end
                    4'hD:
                    begin
                        vf_we = 1'b1;
                        vf_wd = 8'd0;
                        row_next = 5'd0;
                        if (on != 4'd0 && !drow[5])
                        begin
                            mem_addr   = i_reg;
                            state_next = S_DREAD;
                        end
                    end
                    4'hE:
                    begin
                        if (onn == 8'h9E)
                        begin
                            if (key_hit) pc_next = pc_reg + 12'd2;
                        end
                        else if (onn == 8'hA1)
                        begin
                            if (!key_hit) pc_next = pc_reg + 12'd2;
                        end
                        else
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    default: unk_next = 1'b1;
                endcase
            end
            S_CLEAR:
            begin
                fb_we = 1'b1;
                fb_wa = row_reg;
                fb_wd = 64'd0;
                row_next = row_reg + 5'd1;
                if (row_reg == 5'd31)
                begin
                    state_next = S_DONE;
                end
            end
            S_DREAD:
            begin
                // hold the sprite address so the byte is still there for the XOR
                mem_addr   = i_reg + {7'd0, row_reg};
                state_next = S_DXOR;
            end
            S_DXOR:
            begin
                fb_we      = 1'b1;
                fb_wa      = drow[4:0];
                fb_wd      = fb_reg[drow[4:0]] ^ smask;
                drawn_next = 1'b1;
                if ((fb_reg[drow[4:0]] & smask) != 64'd0)
                begin
                    vf_we = 1'b1;
                    vf_wd = 8'd1;
                end
                row_next = row_reg + 5'd1;
                if ({1'b0, row_reg} + 6'd1 >= {2'b0, on} || drow == 6'd31)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_addr   = i_reg + {7'd0, row_reg} + 12'd1;
                    state_next = S_DREAD;
                end
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // state, architectural registers and register files
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            quirk_reg <= 1'b0;
            pc_reg    <= PC_RESET;
            i_reg     <= 12'd0;
            sp_reg    <= '0;
            row_reg   <= 5'd0;
            drawn_reg <= 1'b0;
            unk_reg   <= 1'b0;
            disp_reg  <= 64'd0;
            for (int k = 0; k < 16; k++) v_reg[k] <= 8'd0;
            for (int k = 0; k < STACK_DEPTH; k++) stk_reg[k] <= 12'd0;
            for (int k = 0; k < 32; k++) fb_reg[k] <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            i_reg     <= i_next;
            sp_reg    <= sp_next;
            row_reg   <= row_next;
            drawn_reg <= drawn_next;
            unk_reg   <= unk_next;
            disp_reg  <= disp_next;
            if (cfg_we)
            begin
                quirk_reg <= cfg_wdata;
            end
            // the flag write wins when VF is also the target
            if (v_we && !(vf_we && v_wa == 4'hF))
            begin
                v_reg[v_wa] <= v_wd;
            end
            if (vf_we)
            begin
                v_reg[15] <= vf_wd;
            end
            if (stk_we)
            begin
                stk_reg[sp_reg] <= pc_reg;
            end
            if (fb_we)
            begin
                fb_reg[fb_wa] <= fb_wd;
            end
        end
    end

    // capture the beat, the opcode bytes and the sprite origin
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_HI)
        begin
            hi_reg <= mem_rdata;
        end
        if (state_reg == S_LO)
        begin
            op_reg <= {hi_reg, mem_rdata};
        end
        if (state_reg == S_EXEC)
        begin
            px_reg <= vx[5:0];
            py_reg <= vy[4:0];
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp.program_counter = pc_reg;
    assign rsp.index_value     = i_reg;
    assign rsp.flag_value      = v_reg[15];
    assign rsp.screen_changed  = drawn_reg;
    assign rsp.unknown_opcode  = unk_reg;
    assign rsp.display_row     = disp_reg;

    `C8_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `C8_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `C8_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
endmodule

// File: design/c8_ram.sv
// ----------------------------------------------------------------------------
// c8_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: design/c8_alu.sv
// ----------------------------------------------------------------------------
// c8_alu: shared 8-bit arithmetic unit
// Add, subtract, logic, shift and compare for the 8XY_ group and skips.
// ----------------------------------------------------------------------------
module c8_alu (
    input  logic [3:0] op,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic [7:0] res,
    output logic       flag
);
    logic [8:0] sum;
    logic [8:0] dif;
    logic [8:0] rdif;

    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        dif  = {1'b0, a} - {1'b0, b};
        rdif = {1'b0, b} - {1'b0, a};
        res  = b;
        flag = 1'b0;
        case (op)
            4'h0: res = b;
            4'h1: res = a | b;
            4'h2: res = a & b;
            4'h3: res = a ^ b;
            4'h4:
            begin
                res  = sum[7:0];
                flag = sum[8];
            end
            4'h5:
            begin
                res  = dif[7:0];
                flag = ~dif[8];
            end
            4'h6:
            begin
                res  = {1'b0, a[7:1]};
                flag = a[0];
            end
            4'h7:
            begin
                res  = rdif[7:0];
                flag = ~rdif[8];
            end
            4'hE:
            begin
                res  = {a[6:0], 1'b0};
                flag = a[7];
            end
            default:
            begin
                res  = a;
                flag = 1'b0;
            end
        endcase
    end
endmodule
